// File: sv/pvs_pkg.sv
// Shared types, codes and constants of the polyline vertex snapper.
package pvs_pkg;

  localparam int COORD_W          = 31;
  localparam int COUNT_OUT_W      = 11;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int CFG_AW           = 3;
  localparam int CFG_DW           = 32;

  // register index, taken from the word address bit of paddr
  localparam logic REG_PREFER_CROSS = 1'b0;
  localparam logic REG_ALLOW_DIAG   = 1'b1;

  typedef enum logic [2:0] {
    ST_APPEND  = 3'd0,
    ST_SKIP    = 3'd1,
    ST_REPLACE = 3'd2,
    ST_REMOVE  = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEAR   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_HOR  = 2'd0,
    K_RISE = 2'd1,
    K_VER  = 2'd2,
    K_FALL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_VER,
    MODE_HOR,
    MODE_DIAG
  } mode_t;

  typedef struct packed {
    logic prefer_cross;
    logic allow_diagonal;
  } cfg_t;

  typedef struct packed {
    logic                      zero;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    kind_t                     kind;
    logic                      prev_same;
    logic                      at_prev;
  } snap_t;

endpackage

// File: sv/pvs_in_if.sv
// Input channel: offered point or clear command.
interface pvs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [pvs_pkg::COORD_W-1:0] new_x;
  logic signed [pvs_pkg::COORD_W-1:0] new_y;

  modport source (output valid, action, new_x, new_y, input ready);
  modport sink (input valid, action, new_x, new_y, output ready);
endinterface

// File: sv/pvs_out_if.sv
// Result channel: snapped point, status and vertex count.
interface pvs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pvs_pkg::COORD_W-1:0]     snapped_x;
  logic signed [pvs_pkg::COORD_W-1:0]     snapped_y;
  logic [2:0]                             status;
  logic [1:0]                             segment_kind;
  logic [pvs_pkg::COUNT_OUT_W-1:0]        vertex_count;

  modport source (output valid, snapped_x, snapped_y, status, segment_kind, vertex_count,
                  input ready);
  modport sink (input valid, snapped_x, snapped_y, status, segment_kind, vertex_count,
                output ready);
endinterface

// File: sv/polyline_vertex_snapper.sv
// Polyline vertex snapper: channels, vertex stack memory and update logic.
//
// Items enter on in_ch (valid/ready): action 0 offers a point, action 1
// clears the polyline. Every item gives exactly one result on out_ch:
// the snapped point, a status code, the kind of the new segment and the
// number of stored vertices afterwards.
// At the transfer the top two vertices are read from the vertex memory,
// whose registered read returns them in the next cycle; the point is
// then snapped, and once the output register is free the stack is
// written back and the result is loaded into it. The read-modify-write
// through the memory means that a new item is taken only after the last
// one has moved on to the output register.
// The output register lets a new item be taken while a result still
// waits. When the receiver stalls, the item in work holds with its stack
// update until the output register frees, and in_ch.ready stays low.
// Reset empties the stack (count zero), sets prefer_cross to 0 and
// allow_diagonal to 1. The memory itself is not cleared: entries at or
// above the count never affect a result.
// Registers on cfg_*: prefer_cross at byte address 0, allow_diagonal at 4.
module polyline_vertex_snapper #(
  parameter int MAX_VERTICES = pvs_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pvs_in_if.sink                     in_ch,
  pvs_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pvs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pvs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pvs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import pvs_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  cfg_t  cfg;
  snap_t snap;

  logic                      busy_r, busy_nxt;
  logic                      act_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [CW-1:0]             count_r, count_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] sx_r, sy_r, res_x, res_y;
  status_t                   st_r, res_st;
  kind_t                     kind_r, res_kind;
  logic [COUNT_OUT_W-1:0]    vc_r;

  logic                      accept, complete;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [COORD_W-1:0] lx, ly, qx, qy;

  pvs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign complete    = busy_r && (!out_valid_r || out_ch.ready);

  pvs_vertex_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_x      (res_x),
    .wr_y      (res_y),
    .rd_en     (accept),
    .rd_addr_a (AW'(count_r - CW'(1))),
    .rd_addr_b (AW'(count_r - CW'(2))),
    .rd_a_x    (lx),
    .rd_a_y    (ly),
    .rd_b_x    (qx),
    .rd_b_y    (qy)
  );

  pvs_snap u_snap (
    .cfg  (cfg),
    .px   (px_r),
    .py   (py_r),
    .lx   (lx),
    .ly   (ly),
    .qx   (qx),
    .qy   (qy),
    .snap (snap)
  );

  // stack update and result of the item in work
  always_comb begin
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(count_r);
    res_x     = snap.sx;
    res_y     = snap.sy;
    res_kind  = snap.kind;
    res_st    = ST_APPEND;
    if (act_r) begin
      count_nxt = '0;
      res_x     = '0;
      res_y     = '0;
      res_kind  = K_HOR;
      res_st    = ST_CLEAR;
    end else if (count_r == '0) begin
      res_x     = px_r;
      res_y     = py_r;
      res_kind  = K_HOR;
      wr_en     = 1'b1;
      count_nxt = CW'(1);
    end else if (snap.zero) begin
      res_x    = px_r;
      res_y    = py_r;
      res_kind = K_HOR;
      res_st   = ST_SKIP;
    end else if (count_r > CW'(1) && snap.prev_same) begin
      if (snap.at_prev) begin
        count_nxt = count_r - CW'(1);
        res_st    = ST_REMOVE;
      end else begin
        wr_en   = 1'b1;
        wr_addr = AW'(count_r - CW'(1));
        res_st  = ST_REPLACE;
      end
    end else if (count_r >= CW'(MAX_VERTICES)) begin
      res_st = ST_FULL;
    end else begin
      wr_en     = 1'b1;
      count_nxt = count_r + CW'(1);
    end
    // hold everything until the output register can take the result
    if (!complete) begin
      wr_en     = 1'b0;
      count_nxt = count_r;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (complete) busy_nxt = 1'b0;
    if (accept)   busy_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (complete)     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_ch.action;
      px_r  <= in_ch.new_x;
      py_r  <= in_ch.new_y;
    end
    if (complete) begin
      sx_r   <= res_x;
      sy_r   <= res_y;
      st_r   <= res_st;
      kind_r <= res_kind;
      vc_r   <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.snapped_x    = sx_r;
  assign out_ch.snapped_y    = sy_r;
  assign out_ch.status       = st_r;
  assign out_ch.segment_kind = kind_r;
  assign out_ch.vertex_count = vc_r;

endmodule

// File: sv/pvs_cfg.sv
// APB configuration registers: prefer_cross and allow_diagonal.
module pvs_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pvs_pkg::CFG_AW-1:0] paddr,
  input  logic [pvs_pkg::CFG_DW-1:0] pwdata,
  output logic [pvs_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output pvs_pkg::cfg_t              cfg
);
  import pvs_pkg::*;

  logic big_r, big_nxt;
  logic diag_r, diag_nxt;
  logic idx;
  logic wr;
  logic rd_bit;

  assign idx    = paddr[CFG_AW-1];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    big_nxt  = big_r;
    diag_nxt = diag_r;
    rd_bit   = 1'b0;
    unique case (idx)
      REG_PREFER_CROSS: begin
        rd_bit = big_r;
        if (wr) big_nxt = pwdata[0];
      end
      REG_ALLOW_DIAG: begin
        rd_bit = diag_r;
        if (wr) diag_nxt = pwdata[0];
      end
      default: rd_bit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_r  <= 1'b0;
      diag_r <= 1'b1;
    end else begin
      big_r  <= big_nxt;
      diag_r <= diag_nxt;
    end
  end

  assign prdata             = {{(CFG_DW-1){1'b0}}, rd_bit};
  assign cfg.prefer_cross   = big_r;
  assign cfg.allow_diagonal = diag_r;

endmodule

// File: sv/pvs_vertex_mem.sv
// Vertex stack memory: one write port, two registered read ports.
module pvs_vertex_mem #(
  parameter int DEPTH = pvs_pkg::MAX_VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [pvs_pkg::COORD_W-1:0] wr_x,
  input  logic signed [pvs_pkg::COORD_W-1:0] wr_y,
  input  logic                               rd_en,
  input  logic [AW-1:0]                      rd_addr_a,
  input  logic [AW-1:0]                      rd_addr_b,
  output logic signed [pvs_pkg::COORD_W-1:0] rd_a_x,
  output logic signed [pvs_pkg::COORD_W-1:0] rd_a_y,
  output logic signed [pvs_pkg::COORD_W-1:0] rd_b_x,
  output logic signed [pvs_pkg::COORD_W-1:0] rd_b_y
);
  import pvs_pkg::*;

  logic signed [COORD_W-1:0] mem_x [DEPTH];
  logic signed [COORD_W-1:0] mem_y [DEPTH];
  logic signed [COORD_W-1:0] rd_a_x_r, rd_a_y_r, rd_b_x_r, rd_b_y_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_x_r <= mem_x[rd_addr_a];
      rd_a_y_r <= mem_y[rd_addr_a];
      rd_b_x_r <= mem_x[rd_addr_b];
      rd_b_y_r <= mem_y[rd_addr_b];
    end
  end

  assign rd_a_x = rd_a_x_r;
  assign rd_a_y = rd_a_y_r;
  assign rd_b_x = rd_b_x_r;
  assign rd_b_y = rd_b_y_r;

endmodule

// File: sv/pvs_snap.sv
// Snapping datapath: snaps the offered point against the last vertex and
// compares the new segment with the previous one.
module pvs_snap (
  input  pvs_pkg::cfg_t                      cfg,
  input  logic signed [pvs_pkg::COORD_W-1:0] px,
  input  logic signed [pvs_pkg::COORD_W-1:0] py,
  input  logic signed [pvs_pkg::COORD_W-1:0] lx,
  input  logic signed [pvs_pkg::COORD_W-1:0] ly,
  input  logic signed [pvs_pkg::COORD_W-1:0] qx,
  input  logic signed [pvs_pkg::COORD_W-1:0] qy,
  output pvs_pkg::snap_t                     snap
);
  import pvs_pkg::*;

  localparam int DW = COORD_W + 1;

  logic signed [DW-1:0] dx, dy, ex, ey, sdx, sdy, sum_x, sum_y;
  logic [DW-1:0]        ax, ay;
  logic [DW:0]          ax2, ay2;
  logic                 big;
  mode_t                mode;
  kind_t                prev_kind;

  always_comb begin
    big = cfg.prefer_cross;
    dx  = DW'(px) - DW'(lx);
    dy  = DW'(py) - DW'(ly);
    ax  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    ax2 = {ax, 1'b0};
    ay2 = {ay, 1'b0};

    if (!cfg.allow_diagonal) begin
      if (ax < ay) mode = (big && dx != '0) ? MODE_HOR : MODE_VER;
      else         mode = (big && dy != '0) ? MODE_VER : MODE_HOR;
    end else if ({1'b0, ay} > ax2) begin
      mode = (big && dx != '0) ? MODE_DIAG : MODE_VER;
    end else if ({1'b0, ax} > ay2) begin
      mode = (big && dy != '0) ? MODE_DIAG : MODE_HOR;
    end else if (big && ay > ax) begin
      mode = MODE_VER;
    end else if (big && ay < ax) begin
      mode = MODE_HOR;
    end else begin
      mode = MODE_DIAG;
    end

    // shorten the larger delta to the smaller one, keep its sign
    sdx = dx;
    sdy = dy;
    if (ay > ax) sdy = dy[DW-1] ? -$signed(ax) : $signed(ax);
    else         sdx = dx[DW-1] ? -$signed(ay) : $signed(ay);
    sum_x = DW'(lx) + sdx;
    sum_y = DW'(ly) + sdy;

    snap.zero = (dx == '0) && (dy == '0);
    unique case (mode)
      MODE_VER: begin
        snap.sx   = lx;
        snap.sy   = py;
        snap.kind = K_VER;
      end
      MODE_HOR: begin
        snap.sx   = px;
        snap.sy   = ly;
        snap.kind = K_HOR;
      end
      default: begin
        snap.sx   = (ay > ax) ? px : sum_x[COORD_W-1:0];
        snap.sy   = (ay > ax) ? sum_y[COORD_W-1:0] : py;
        snap.kind = (sdy == sdx) ? K_RISE : K_FALL;
      end
    endcase

    // direction of the segment from the vertex before the last one to the last one
    ex = DW'(lx) - DW'(qx);
    ey = DW'(ly) - DW'(qy);
    if (ey == -ex)      prev_kind = K_FALL;
    else if (ey == ex)  prev_kind = K_RISE;
    else if (ex == '0)  prev_kind = K_VER;
    else                prev_kind = K_HOR;

    snap.prev_same = (prev_kind == snap.kind);
    snap.at_prev   = (snap.sx == qx) && (snap.sy == qy);
  end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the polyline vertex snapper.
`timescale 1ns / 100ps

module tb_top;
  import pvs_pkg::*;

  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 31'sh4000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 31'sh3FFF_FFFF;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct {
    logic                      action;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_cmd_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    status_t                   status;
    kind_t                     kind;
    logic [COUNT_OUT_W-1:0]    count;
  } snap_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  pvs_in_if  in_ch ();
  pvs_out_if out_ch ();

  polyline_vertex_snapper dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: vertex stack and register copies
  logic signed [COORD_W-1:0] vert_x [MAX_VERTICES_DEF];
  logic signed [COORD_W-1:0] vert_y [MAX_VERTICES_DEF];
  int   vert_count = 0;
  logic cfg_big = 1'b0;
  logic cfg_diag = 1'b1;

  point_cmd_t   pending_points [$];
  snap_result_t expected_snaps [$];
  int tx_idle_pct;
  int rx_idle_pct;
  int error_count = 0;
  int queued_items = 0;
  logic holdoff_arm;
  logic holdoff_done;
  int holdoff_left;

  function automatic snap_result_t snap_point(logic action, logic signed [COORD_W-1:0] nx,
                                              logic signed [COORD_W-1:0] ny);
    snap_result_t r;
    longint px, py, lx, ly, dx, dy, ax, ay, qx, qy, pdx, pdy;
    mode_t mode;
    kind_t kind, prev_kind;
    int n;
    px = nx;
    py = ny;
    r.x = nx;
    r.y = ny;
    r.status = ST_APPEND;
    r.kind = K_HOR;
    if (action == ACT_CLEAR) begin
      vert_count = 0;
      r.x = '0;
      r.y = '0;
      r.status = ST_CLEAR;
      r.count = '0;
      return r;
    end
    n = vert_count;
    if (n == 0) begin
      vert_x[0] = nx;
      vert_y[0] = ny;
      vert_count = 1;
      r.count = COUNT_OUT_W'(1);
      return r;
    end
    lx = vert_x[n-1];
    ly = vert_y[n-1];
    dx = px - lx;
    dy = py - ly;
    if (dx == 0 && dy == 0) begin
      r.status = ST_SKIP;
      r.count = COUNT_OUT_W'(n);
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;

    if (!cfg_diag) begin
      if (ax < ay) mode = (cfg_big && dx != 0) ? MODE_HOR : MODE_VER;
      else mode = (cfg_big && dy != 0) ? MODE_VER : MODE_HOR;
    end else if (ay > 2 * ax) begin
      mode = (cfg_big && dx != 0) ? MODE_DIAG : MODE_VER;
    end else if (ax > 2 * ay) begin
      mode = (cfg_big && dy != 0) ? MODE_DIAG : MODE_HOR;
    end else if (cfg_big && ay > ax) begin
      mode = MODE_VER;
    end else if (cfg_big && ay < ax) begin
      mode = MODE_HOR;
    end else begin
      mode = MODE_DIAG;
    end

    case (mode)
      MODE_VER: begin
        px = lx;
        kind = K_VER;
      end
      MODE_HOR: begin
        py = ly;
        kind = K_HOR;
      end
      default: begin
        // shorten the larger delta to the smaller, keep its sign
        if (ay > ax) begin
          dy = (dy < 0) ? -ax : ax;
          py = ly + dy;
        end else begin
          dx = (dx < 0) ? -ay : ay;
          px = lx + dx;
        end
        kind = (dy == dx) ? K_RISE : K_FALL;
      end
    endcase
    r.x = px[COORD_W-1:0];
    r.y = py[COORD_W-1:0];
    r.kind = kind;

    if (n > 1) begin
      qx = vert_x[n-2];
      qy = vert_y[n-2];
      pdx = lx - qx;
      pdy = ly - qy;
      if (pdy == -pdx) prev_kind = K_FALL;
      else if (pdy == pdx) prev_kind = K_RISE;
      else if (pdx == 0) prev_kind = K_VER;
      else prev_kind = K_HOR;
      if (prev_kind == kind) begin
        if (px == qx && py == qy) begin
          vert_count = n - 1;
          r.status = ST_REMOVE;
        end else begin
          vert_x[n-1] = px[COORD_W-1:0];
          vert_y[n-1] = py[COORD_W-1:0];
          r.status = ST_REPLACE;
        end
        r.count = COUNT_OUT_W'(vert_count);
        return r;
      end
    end
    if (n >= MAX_VERTICES_DEF) begin
      r.status = ST_FULL;
    end else begin
      vert_x[n] = px[COORD_W-1:0];
      vert_y[n] = py[COORD_W-1:0];
      vert_count = n + 1;
    end
    r.count = COUNT_OUT_W'(vert_count);
    return r;
  endfunction

  // Input driver: predict on each transfer, then offer the next point or idle
  always @(posedge clk) begin
    point_cmd_t cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_snaps.push_back(snap_point(in_ch.action, in_ch.new_x, in_ch.new_y));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cmd = pending_points.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.action <= cmd.action;
          in_ch.new_x  <= cmd.x;
          in_ch.new_y  <= cmd.y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with one long hold-off once armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_arm && !holdoff_done) begin
      out_ch.ready <= 1'b0;
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      out_ch.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    snap_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_snaps.size() == 0) begin
        $error("result with no pending expectation: x %0d y %0d status %0d",
               out_ch.snapped_x, out_ch.snapped_y, out_ch.status);
        error_count++;
      end else begin
        want = expected_snaps.pop_front();
        if (out_ch.snapped_x !== want.x) begin
          $error("snapped_x: expected %0d, got %0d", want.x, out_ch.snapped_x);
          error_count++;
        end
        if (out_ch.snapped_y !== want.y) begin
          $error("snapped_y: expected %0d, got %0d", want.y, out_ch.snapped_y);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.segment_kind !== want.kind) begin
          $error("segment_kind: expected %0d, got %0d", want.kind, out_ch.segment_kind);
          error_count++;
        end
        if (out_ch.vertex_count !== want.count) begin
          $error("vertex_count: expected %0d, got %0d", want.count, out_ch.vertex_count);
          error_count++;
        end
      end
    end
  end

  task automatic push_point(longint x, longint y);
    point_cmd_t cmd;
    cmd.action = ACT_POINT;
    cmd.x = x[COORD_W-1:0];
    cmd.y = y[COORD_W-1:0];
    pending_points.push_back(cmd);
    queued_items++;
  endtask

  task automatic push_clear();
    point_cmd_t cmd;
    cmd.action = ACT_CLEAR;
    cmd.x = COORD_W'($urandom);
    cmd.y = COORD_W'($urandom);
    pending_points.push_back(cmd);
    queued_items++;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Random walk from a random start: small, axis, diagonal, threshold, zero,
  // repeat and reverse steps, so replacement and removal come up often
  task automatic gen_walk(int steps);
    longint cx, cy, dx, dy, last_dx, last_dy, j;
    int k, sx, sy;
    cx = longint'($urandom_range(32'h7000_0000)) - 64'sh3800_0000;
    cy = longint'($urandom_range(32'h7000_0000)) - 64'sh3800_0000;
    last_dx = 1;
    last_dy = 0;
    push_point(cx, cy);
    repeat (steps) begin
      k  = $urandom_range(1, 400);
      sx = $urandom_range(1) ? 1 : -1;
      sy = $urandom_range(1) ? 1 : -1;
      case ($urandom_range(6))
        0: begin
          dx = sx * int'($urandom_range(60));
          dy = sy * int'($urandom_range(60));
        end
        1: begin
          if ($urandom_range(1)) begin
            dx = sx * k;
            dy = 0;
          end else begin
            dx = 0;
            dy = sy * k;
          end
        end
        2: begin
          dx = sx * k;
          dy = sy * k;
        end
        3: begin
          // land on or next to the 2:1 threshold
          j = 2 * k + $urandom_range(2) - 1;
          if ($urandom_range(1)) begin
            dx = sx * k;
            dy = sy * j;
          end else begin
            dx = sx * j;
            dy = sy * k;
          end
        end
        4: begin
          dx = 0;
          dy = 0;
        end
        5: begin
          dx = -last_dx;
          dy = -last_dy;
        end
        default: begin
          dx = last_dx;
          dy = last_dy;
        end
      endcase
      cx += dx;
      cy += dy;
      last_dx = dx;
      last_dy = dy;
      push_point(cx, cy);
    end
  endtask

  task automatic gen_mixed(int count);
    int start;
    int pick;
    start = queued_items;
    while (queued_items - start < count) begin
      pick = $urandom_range(99);
      if (pick < 5) push_clear();
      else if (pick < 15) push_point(rand_coord(), rand_coord());
      else gen_walk($urandom_range(3, 30));
    end
  endtask

  // Alternate horizontal and vertical steps so every point appends, past full
  task automatic gen_staircase();
    longint cx, cy;
    push_clear();
    cx = longint'(COORD_MIN) + 1000;
    cy = longint'(COORD_MIN) + 1000;
    push_point(cx, cy);
    for (int i = 0; i < MAX_VERTICES_DEF + 8; i++) begin
      if (i % 2 == 0) cx += $urandom_range(1, 500);
      else cy += $urandom_range(1, 500);
      push_point(cx, cy);
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || expected_snaps.size() != 0 || in_ch.valid)
      @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(CFG_DW-1){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_PREFER_CROSS) cfg_big = value;
    else cfg_diag = value;
  endtask

  task automatic start_phase(logic big, logic diag, int tx_pct, int rx_pct);
    wait_drained();
    cfg_write(REG_PREFER_CROSS, big);
    cfg_write(REG_ALLOW_DIAG, diag);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    holdoff_arm  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, first point, zero delta, replace, remove, clear
    start_phase(1'b0, 1'b1, 10, 76);
    push_clear();
    push_point(COORD_MIN, COORD_MAX);
    push_point(COORD_MIN, COORD_MAX);
    push_point(COORD_MAX, COORD_MIN);
    push_point(0, 0);
    push_clear();
    push_point(0, 0);
    push_point(100, 0);
    push_point(200, 30);
    push_point(0, 5);
    push_point(0, 100);
    push_point(30, 50);
    push_point(50, 50);
    push_point(60, 70);
    push_point(100, 61);
    push_point(100, 200);
    push_point(-1, -1);
    push_clear();

    start_phase(1'b1, 1'b1, 10, 76);
    gen_mixed(230);
    start_phase(1'b0, 1'b0, 10, 76);
    gen_mixed(230);
    start_phase(1'b1, 1'b0, 76, 10);
    gen_mixed(230);
    // Fill the store, then keep walking while full
    start_phase(1'b0, 1'b1, 76, 10);
    gen_staircase();
    gen_walk(20);
    start_phase(1'b1, 1'b1, 0, 0);
    holdoff_arm <= 1'b1;
    gen_mixed(230);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
